FILE: design/gcdl_pkg.sv
`default_nettype none

package gcdl_pkg;

    // Operand width; the multiple is twice as wide.
    localparam int OPERAND_WIDTH  = 16;
    localparam int MULTIPLE_WIDTH = 2 * OPERAND_WIDTH;

    typedef struct packed {
        logic [OPERAND_WIDTH-1:0] first_value;
        logic [OPERAND_WIDTH-1:0] second_value;
    } gcdl_in_t;

    typedef struct packed {
        logic [OPERAND_WIDTH-1:0]  divisor;
        logic [MULTIPLE_WIDTH-1:0] multiple;
        logic                      bad_operand;
    } gcdl_out_t;

endpackage

`default_nettype wire

FILE: design/gcd_lcm_unit.sv
`default_nettype none

// gcd_lcm_unit: greatest common divisor and least common multiple.
//
// Input channel (in_valid/in_ready/in_word) takes one word with two unsigned
// operands. Output channel (out_valid/out_ready/out_word) returns one word
// per input: the divisor, the multiple (first * second / divisor) and a
// bad_operand flag. A zero operand gives zero results with the flag set.
//
// One shared add/subtract unit runs three phases under a small sequencer:
//   binary GCD   : shift, swap or subtract-shift steps
//   division     : restoring, first operand over the divisor
//   multiply     : shift-add of quotient times second operand
// in_ready is high only while the sequencer is idle, so one item is in
// flight at a time. A finished result sits in the output register; the
// next item is accepted while it waits. If the receiver stalls and a second
// result finishes, the sequencer holds it until the output register frees.
// Reset (rst_n, asynchronous, active low) empties the output register and
// returns the sequencer to idle.

module gcd_lcm_unit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire gcdl_pkg::gcdl_in_t  in_word,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output gcdl_pkg::gcdl_out_t    out_word
);
    import gcdl_pkg::*;

    localparam int W  = OPERAND_WIDTH;
    localparam int KW = $clog2(W);
    localparam int CW = $clog2(W);
    localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GCD  = 3'd1;
    localparam logic [2:0] ST_DIV  = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [W-1:0]  a_reg, a_next;     // gcd working operand
    logic [W-1:0]  b_reg, b_next;     // gcd working operand
    logic [KW-1:0] k_reg, k_next;     // shared factors of two
    logic [W-1:0]  g_reg, g_next;     // divisor
    logic [W-1:0]  acc_reg, acc_next; // remainder, then product high half
    logic [W-1:0]  q_reg, q_next;     // dividend -> quotient -> product low half
    logic [W-1:0]  y_reg, y_next;     // second operand
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          err_reg, err_next;
    logic          out_valid_reg, out_valid_next;
    gcdl_out_t     out_word_reg, out_word_next;

    // Shared adder
    logic [W:0]    add_a;
    logic [W-1:0]  add_b;
    logic          add_sub;
    logic [W+1:0]  add_sum;
    logic          borrow;

    logic [W:0]    rem_sh;
    logic [W:0]    mul_s;
    logic          slot_free;
    logic          in_fire;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    assign rem_sh = {acc_reg, q_reg[W-1]};

    always_comb
    begin
        add_a   = {1'b0, a_reg};
        add_b   = b_reg;
        add_sub = 1'b1;
        unique case (state_reg)
            ST_DIV:
            begin
                add_a = rem_sh;
                add_b = g_reg;
            end
            ST_MUL:
            begin
                add_a   = {1'b0, acc_reg};
                add_b   = y_reg;
                add_sub = 1'b0;
            end
            default:
            begin
                add_a   = {1'b0, a_reg};
                add_b   = b_reg;
                add_sub = 1'b1;
            end
        endcase
    end

    assign add_sum = {1'b0, add_a}
                   + ({2'b00, add_b} ^ {(W+2){add_sub}})
                   + {{(W+1){1'b0}}, add_sub};
    assign borrow  = add_sum[W+1];

    assign mul_s = q_reg[0] ? add_sum[W:0] : {1'b0, acc_reg};

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        g_next         = g_reg;
        acc_next       = acc_reg;
        q_next         = q_reg;
        y_next         = y_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_word_next  = out_word_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    a_next   = in_word.first_value;
                    b_next   = in_word.second_value;
                    q_next   = in_word.first_value;
                    y_next   = in_word.second_value;
                    k_next   = '0;
                    cnt_next = '0;
                    acc_next = '0;
                    if (in_word.first_value == '0 || in_word.second_value == '0)
                    begin
                        err_next   = 1'b1;
                        g_next     = '0;
                        q_next     = '0;
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        err_next   = 1'b0;
                        state_next = ST_GCD;
                    end
                end
            end
            ST_GCD:
            begin
                if (add_sum[W:0] == '0)
                begin
                    g_next     = W'(a_reg << k_reg);
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + KW'(1);
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else if (borrow)
                begin
                    // a < b: swap, subtract on the next pass
                    a_next = b_reg;
                    b_next = a_reg;
                end
                else
                begin
                    a_next = add_sum[W:1];
                end
            end
            ST_DIV:
            begin
                if (!borrow)
                begin
                    acc_next = add_sum[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                // acc is zero on entry from the division (remainder is zero)
                acc_next = mul_s[W:1];
                q_next   = {mul_s[0], q_reg[W-1:1]};
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (slot_free)
                begin
                    out_valid_next            = 1'b1;
                    out_word_next.divisor     = g_reg;
                    out_word_next.multiple    = {acc_reg, q_reg};
                    out_word_next.bad_operand = err_reg;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            k_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        g_reg        <= g_next;
        acc_reg      <= acc_next;
        q_reg        <= q_next;
        y_reg        <= y_next;
        err_reg      <= err_next;
        out_word_reg <= out_word_next;
    end

    // An accepted word always starts the sequencer.
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg != ST_IDLE)
        else $error("accepted word did not start sequencer");

    // The binary GCD phase never works on a zero operand.
    a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_GCD |-> (a_reg != '0 && b_reg != '0))
        else $error("zero operand inside gcd loop");

    // A freshly loaded result is consistent with its error flag.
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN && slot_free) |=>
            (out_word_reg.bad_operand
                ? (out_word_reg.divisor == '0 && out_word_reg.multiple == '0)
                : (out_word_reg.divisor != '0 && out_word_reg.multiple != '0)))
        else $error("result fields disagree with bad_operand");

endmodule

`default_nettype wire

FILE: tb/gcd_lcm_unit_tb.sv
module gcd_lcm_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcdl_pkg::*;

    // Run shape
    localparam int DIRECTED_ROWS = 22;
    localparam int RANDOM_WORDS  = 1000;
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES  = 150;
    localparam int MAX_REPORTS   = 10;

    // One expected result together with the operands that caused it,
    // so a mismatch report can name the input word.
    typedef struct packed {
        gcdl_in_t  operands;
        gcdl_out_t result;
    } pending_t;

    // Directed row: operands, whether the result is typed in, typed result.
    typedef struct packed {
        gcdl_in_t  operands;
        logic      typed;
        gcdl_out_t result;
    } directed_row_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    gcdl_in_t   in_word;
    logic       out_valid;
    logic       out_ready;
    gcdl_out_t  out_word;

    pending_t        pending_results [$];
    directed_row_t   directed_tab [DIRECTED_ROWS];

    int  fail_count    = 0;
    int  words_sent    = 0;
    int  zero_words    = 0;
    int  results_seen  = 0;
    int  hold_requests = 0;   // bumped by the sender, served by the receiver
    int  burst_left    = 0;
    bit  steady_stream = 1'b0;

    always #5 clk = ~clk;

    gcd_lcm_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    // ------------------------------------------------------------------
    // Predictor: Euclid on the operands, multiple = (first / divisor) *
    // second at twice the operand width, so it cannot overflow. A zero
    // operand gives an all-zero result with the error flag set.
    // ------------------------------------------------------------------
    function automatic gcdl_out_t gcd_lcm_of(input gcdl_in_t w);
        logic [OPERAND_WIDTH-1:0]  x;
        logic [OPERAND_WIDTH-1:0]  y;
        logic [OPERAND_WIDTH-1:0]  r;
        logic [MULTIPLE_WIDTH-1:0] quot;
        logic [MULTIPLE_WIDTH-1:0] other;
        gcdl_out_t                 res;
        res = '0;
        x   = w.first_value;
        y   = w.second_value;
        if (x == '0 || y == '0)
        begin
            res.bad_operand = 1'b1;
            return res;
        end
        while (y != '0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        quot         = MULTIPLE_WIDTH'(w.first_value / x);
        other        = MULTIPLE_WIDTH'(w.second_value);
        res.divisor  = x;
        res.multiple = quot * other;
        return res;
    endfunction

    // Random operand pair. Mostly plain random or pairs with a shared
    // factor (the interesting divisors); the rest covers small values,
    // equal operands, powers of two, values near the top and zeros.
    function automatic gcdl_in_t random_operands();
        gcdl_in_t w;
        int       sel;
        int       k;
        sel = $urandom_range(0, 99);
        w.first_value  = OPERAND_WIDTH'($urandom);
        w.second_value = OPERAND_WIDTH'($urandom);
        if (sel < 30)
        begin
            // full-range random, already set
        end
        else if (sel < 58)
        begin
            k = $urandom_range(2, 400);
            w.first_value  = OPERAND_WIDTH'(k * $urandom_range(1, 65535 / k));
            w.second_value = OPERAND_WIDTH'(k * $urandom_range(1, 65535 / k));
        end
        else if (sel < 68)
        begin
            w.first_value  = OPERAND_WIDTH'($urandom_range(1, 64));
            w.second_value = OPERAND_WIDTH'($urandom_range(1, 64));
        end
        else if (sel < 75)
            w.second_value = w.first_value;
        else if (sel < 82)
        begin
            w.first_value  = 16'h1 << $urandom_range(0, 15);
            w.second_value = w.second_value << $urandom_range(0, 15);
        end
        else if (sel < 90)
        begin
            w.first_value  = OPERAND_WIDTH'(16'hFFFF - $urandom_range(0, 255));
            w.second_value = OPERAND_WIDTH'(16'hFFFF - $urandom_range(0, 4095));
        end
        else if (sel < 94)
            w.first_value = '0;
        else if (sel < 98)
            w.second_value = '0;
        else
            w = '0;
        return w;
    endfunction

    task automatic flag_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t ns: %s", $time, what);
    endtask

    // Offer one word; called at a falling edge. Valid stays high until the
    // rising edge at which in_ready is seen, then the expectation is queued
    // and the task returns at the next falling edge with valid still high.
    task automatic offer_word(input gcdl_in_t w, input logic typed, input gcdl_out_t typed_res);
        pending_t p;
        in_word  = w;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        p.operands = w;
        p.result   = typed ? typed_res : gcd_lcm_of(w);
        pending_results.push_back(p);
        words_sent++;
        if (w.first_value == '0 || w.second_value == '0)
            zero_words++;
        @(negedge clk);
    endtask

    // Sender pacing: bursts of random length, then usually a gap; gaps are mostly
    // short so they land on every cycle of the block's work, sometimes long
    // enough to let the block go fully idle. steady_stream turns them off.
    task automatic pace_sender();
        int gap;
        gap = 0;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0 && !steady_stream)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0)
                gap = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 15);
            if (gap > 0)
            begin
                in_valid = 1'b0;
                in_word  = $urandom;   // junk while idle
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: out_ready follows a pattern that is redrawn at random (always
    // ready, coin flip, one in four, mostly ready). On a hold request it drops
    // ready for a long hold-off so the block backs up.
    // ------------------------------------------------------------------
    initial
    begin
        int mode;
        int span;
        int holds_done;
        int tick;
        mode       = 0;
        span       = 0;
        holds_done = 0;
        tick       = 0;
        out_ready  = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else
            begin
                if (span == 0)
                begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(20, 200);
                end
                span--;
                tick++;
                case (mode)
                    0:       out_ready = 1'b1;
                    1:       out_ready = 1'($urandom_range(0, 1));
                    2:       out_ready = (tick % 4 == 0);
                    default: out_ready = ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each accepted word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        pending_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                flag_failure($sformatf("unexpected result word: divisor %0d multiple %0d bad %0b",
                                       out_word.divisor, out_word.multiple,
                                       out_word.bad_operand));
            else
            begin
                want = pending_results.pop_front();
                if (out_word.divisor !== want.result.divisor ||
                    out_word.multiple !== want.result.multiple ||
                    out_word.bad_operand !== want.result.bad_operand)
                    flag_failure($sformatf(
                        "gcd/lcm(%0d, %0d): expected %0d/%0d/%0b, got %0d/%0d/%0b",
                        want.operands.first_value, want.operands.second_value,
                        want.result.divisor, want.result.multiple,
                        want.result.bad_operand, out_word.divisor,
                        out_word.multiple, out_word.bad_operand));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed table, random words, drain, verdict.
    // ------------------------------------------------------------------
    initial
    begin
        // Row layout: first, second, typed, divisor, multiple, bad_operand.
        // Typed rows: zero operands, equal operands, operands of one and 0xFFFF with 0xFFFE.
        directed_tab = '{
            {16'h0000, 16'h0000, 1'b1, 16'h0000, 32'h0000_0000, 1'b1},
            {16'h0000, 16'h1234, 1'b1, 16'h0000, 32'h0000_0000, 1'b1},
            {16'hFFFF, 16'h0000, 1'b1, 16'h0000, 32'h0000_0000, 1'b1},
            {16'h0000, 16'hFFFF, 1'b1, 16'h0000, 32'h0000_0000, 1'b1},
            {16'h0001, 16'h0001, 1'b1, 16'h0001, 32'h0000_0001, 1'b0},
            {16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF, 32'h0000_FFFF, 1'b0},
            {16'h0001, 16'hFFFF, 1'b1, 16'h0001, 32'h0000_FFFF, 1'b0},
            {16'hFFFF, 16'h0001, 1'b1, 16'h0001, 32'h0000_FFFF, 1'b0},
            {16'hFFFF, 16'hFFFE, 1'b1, 16'h0001, 32'hFFFD_0002, 1'b0},
            {16'h8000, 16'h8000, 1'b1, 16'h8000, 32'h0000_8000, 1'b0},
            {16'h8000, 16'h0001, 1'b1, 16'h0001, 32'h0000_8000, 1'b0},
            {16'd1234, 16'd1234, 1'b1, 16'd1234, 32'd1234,      1'b0},
            {16'hFFFE, 16'hFFFD, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            {16'd12,   16'd18,   1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            {16'h8000, 16'h4000, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            {16'hAAAA, 16'h5555, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            // consecutive Fibonacci numbers: longest Euclid chain in range
            {16'd46368, 16'd28657, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            // two large primes
            {16'd65521, 16'd65519, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            {16'h0001, 16'h8000, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            {16'hFF00, 16'h00FF, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            {16'h5A5A, 16'hA5A5, 1'b0, 16'h0000, 32'h0000_0000, 1'b0},
            {16'd30030, 16'd1001, 1'b0, 16'h0000, 32'h0000_0000, 1'b0}
        };

        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_word  = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_tab[i])
        begin
            offer_word(directed_tab[i].operands, directed_tab[i].typed,
                       directed_tab[i].result);
            pace_sender();
        end

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            // receiver holds off while the sender keeps offering
            if (n == 250 || n == 800)
                hold_requests++;
            // sender pauses until every result is back
            if (n == 450)
            begin
                in_valid = 1'b0;
                while (pending_results.size() != 0)
                    @(negedge clk);
            end
            // a stretch of back-to-back words with no sender gaps
            steady_stream = (n >= 600 && n < 720);
            offer_word(random_operands(), 1'b0, '0);
            pace_sender();
        end
        in_valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // watch for stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
            flag_failure($sformatf("%0d results never arrived", pending_results.size()));

        $display("gcd_lcm_unit_tb: %0d words sent (%0d directed, %0d with a zero operand),",
                 words_sent, DIRECTED_ROWS, zero_words);
        $display("  %0d results checked under bursty input and stalled output, %0d failures",
                 results_seen, fail_count);
        if (fail_count == 0)
            $display("** gcd_lcm_unit: PASSED **");
        else
            $display("** gcd_lcm_unit: FAILED **");
        $finish;
    end

    // Safety net: far above the slowest correct run (~1022 words plus gaps,
    // stalls and two long hold-offs).
    initial
    begin
        #8_000_000;
        $display("timeout: %0d words sent, %0d results seen", words_sent, results_seen);
        $display("** gcd_lcm_unit: FAILED **");
        $finish;
    end

endmodule
